@@ hw/rtl/sha256_pkg.sv @@
package sha256_pkg;

    localparam int unsigned NumRounds = 64;

    typedef logic [31:0] word_t;

    // Eight 32-bit words in digest order: index 0 is a / H0, index 7 is h / H7.
    typedef logic [0:7][31:0] work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    localparam work_t InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ hw/rtl/sha256_round.sv @@
module sha256_round (
    input  sha256_pkg::work_t work_in,
    input  sha256_pkg::word_t k_in,
    input  sha256_pkg::word_t w0_in,
    input  sha256_pkg::word_t w1_in,
    input  sha256_pkg::word_t w9_in,
    input  sha256_pkg::word_t w14_in,
    output sha256_pkg::work_t work_out,
    output sha256_pkg::word_t w_new_out
);
    import sha256_pkg::*;

    word_t big0;
    word_t big1;
    word_t choose;
    word_t major;
    word_t t1;
    word_t t2;
    word_t small0;
    word_t small1;

    assign big0 = {work_in[0][1:0], work_in[0][31:2]}
                ^ {work_in[0][12:0], work_in[0][31:13]}
                ^ {work_in[0][21:0], work_in[0][31:22]};
    assign big1 = {work_in[4][5:0], work_in[4][31:6]}
                ^ {work_in[4][10:0], work_in[4][31:11]}
                ^ {work_in[4][24:0], work_in[4][31:25]};
    assign choose = (work_in[4] & work_in[5]) ^ (~work_in[4] & work_in[6]);
    assign major  = (work_in[0] & work_in[1]) ^ (work_in[0] & work_in[2])
                  ^ (work_in[1] & work_in[2]);

    assign t1 = work_in[7] + big1 + choose + k_in + w0_in;
    assign t2 = big0 + major;

    assign work_out = {t1 + t2, work_in[0], work_in[1], work_in[2],
                       work_in[3] + t1, work_in[4], work_in[5], work_in[6]};

    // Schedule word sixteen rounds ahead of the one consumed now.
    assign small0 = {w1_in[6:0], w1_in[31:7]} ^ {w1_in[17:0], w1_in[31:18]}
                  ^ {3'b000, w1_in[31:3]};
    assign small1 = {w14_in[16:0], w14_in[31:17]} ^ {w14_in[18:0], w14_in[31:19]}
                  ^ {10'b0, w14_in[31:10]};
    assign w_new_out = small1 + w9_in + small0 + w0_in;

endmodule

@@ hw/rtl/sha256_byte_stream_hasher.sv @@
// Input is taken one item per cycle while idle; a full 64-byte block then holds off input
// while the single round unit does its 64 rounds and the result is folded into the chain.
// A final item is followed by the 0x80 marker and the padding bytes, one at a time, then
// one or two compressions and eight result transfers, one per cycle while m_ready is high.
// On long messages the round unit sets the pace: no input is taken during a compression.
// Reset (aresetn low, synchronous) restores the initial hash values and clears length and fill.
module sha256_byte_stream_hasher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_msg_byte,
    input  logic                s_byte_present,
    input  logic                s_end_of_message,
    output logic                m_valid,
    input  logic                m_ready,
    output sha256_pkg::word_t   m_digest_word,
    output logic [2:0]          m_word_index,
    output logic                m_last_word
);
    import sha256_pkg::*;

    state_t       state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    work_t        chain_reg, chain_next;
    logic         eom_reg, eom_next;
    logic         mark_done_reg, mark_done_next;
    logic         extra_reg, extra_next;
    logic         final_reg, final_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   out_idx_reg, out_idx_next;

    // Block buffer and message schedule share one shift line: word 0 is the top 32 bits.
    logic [511:0] blk_reg, blk_next;
    work_t        work_reg, work_next;

    work_t        round_out;
    word_t        w_new;
    logic [7:0]   pad_byte;
    logic         len_phase;

    sha256_round u_round (
        .work_in   (work_reg),
        .k_in      (RoundK[rnd_reg]),
        .w0_in     (blk_reg[511:480]),
        .w1_in     (blk_reg[479:448]),
        .w9_in     (blk_reg[223:192]),
        .w14_in    (blk_reg[63:32]),
        .work_out  (round_out),
        .w_new_out (w_new)
    );

    assign len_phase = (fill_reg[5:3] == 3'b111) && !extra_reg;
    assign pad_byte  = len_phase ? len_reg[{~fill_reg[2:0], 3'b000} +: 8] : 8'h00;

    assign m_digest_word = chain_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        chain_next     = chain_reg;
        eom_next       = eom_reg;
        mark_done_next = mark_done_reg;
        extra_next     = extra_reg;
        final_next     = final_reg;
        rnd_next       = rnd_reg;
        out_idx_next   = out_idx_reg;
        blk_next       = blk_reg;
        work_next      = work_reg;
        s_ready        = 1'b0;
        m_valid        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    eom_next = s_end_of_message;
                    if (s_byte_present) begin
                        blk_next  = {blk_reg[503:0], s_msg_byte};
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 64'd8;
                    end
                    if (s_byte_present && (fill_reg == 6'd63)) begin
                        work_next  = chain_reg;
                        rnd_next   = '0;
                        final_next = 1'b0;
                        state_next = ST_ROUND;
                    end else if (s_end_of_message) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                blk_next       = {blk_reg[503:0], 8'h80};
                fill_next      = fill_reg + 6'd1;
                mark_done_next = 1'b1;
                // No room left for the length: it goes into an extra all-padding block.
                extra_next     = (fill_reg[5:3] == 3'b111);
                if (fill_reg == 6'd63) begin
                    // The marker closes this block, so the next one is the length block.
                    extra_next = 1'b0;
                    work_next  = chain_reg;
                    rnd_next   = '0;
                    final_next = 1'b0;
                    state_next = ST_ROUND;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63) begin
                    work_next  = chain_reg;
                    rnd_next   = '0;
                    final_next = !extra_reg;
                    extra_next = 1'b0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                work_next = round_out;
                blk_next  = {blk_reg[479:0], w_new};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'(NumRounds - 1)) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (final_reg) begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end else if (!eom_reg) begin
                    state_next = ST_IDLE;
                end else if (mark_done_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_MARK;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        chain_next     = InitHash;
                        len_next       = '0;
                        fill_next      = '0;
                        eom_next       = 1'b0;
                        mark_done_next = 1'b0;
                        extra_next     = 1'b0;
                        final_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            chain_reg     <= InitHash;
            eom_reg       <= 1'b0;
            mark_done_reg <= 1'b0;
            extra_reg     <= 1'b0;
            final_reg     <= 1'b0;
            rnd_reg       <= '0;
            out_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            chain_reg     <= chain_next;
            eom_reg       <= eom_next;
            mark_done_reg <= mark_done_next;
            extra_reg     <= extra_next;
            final_reg     <= final_next;
            rnd_reg       <= rnd_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

endmodule
